/* hdl/aes_cbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Shared types, constants and the byte-level AES functions.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

	localparam int KEY_BITS_DEF = 128;
	localparam int NUM_ROUNDS   = 10;
	localparam int BLK_BITS     = 128;
	localparam int CNT_W        = 5;
	localparam int IDX_W        = 3;

	localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEYHI = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEYLO = 3'd2;
	localparam logic [IDX_W-1:0] REG_IVHI  = 3'd3;
	localparam logic [IDX_W-1:0] REG_IVLO  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input block and start round 0
		logic round;     // run one round
		logic pad_load;  // load a full padding block as the next plaintext
		logic commit;    // update the chain value from the finished block
		logic chain_iv;  // return the chain value to the IV
		logic decrypt;   // direction of the current block
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_round;
	} dp_sts_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NUM_ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	// Inverse S-box by search of the forward table (constant logic).
	function automatic logic [7:0] inv_sbox(input logic [7:0] v);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (SBOX[i] == v) r = 8'(i);
		end
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block, byte 0 in the top bits.
	function automatic logic [7:0] byte_of(input logic [BLK_BITS-1:0] s, input int i);
		return s[BLK_BITS-1-8*i -: 8];
	endfunction

	function automatic logic [BLK_BITS-1:0] enc_round(input logic [BLK_BITS-1:0] s,
			input logic [BLK_BITS-1:0] k, input logic last_rnd);
		logic [7:0] b [16];
		logic [7:0] o [16];
		logic [7:0] a0, a1, a2, a3;
		logic [BLK_BITS-1:0] r;
		for (int i = 0; i < 16; i++) b[i] = SBOX[byte_of(s, i)];
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				o[rr + 4*c] = b[rr + 4*((c + rr) & 3)];
		if (!last_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
				o[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				o[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				o[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				o[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
		for (int i = 0; i < 16; i++) r[BLK_BITS-1-8*i -: 8] = o[i];
		return r ^ k;
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] a);
		return xt(xt(xt(a))) ^ a;
	endfunction
	function automatic logic [7:0] mul11(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(a) ^ a;
	endfunction
	function automatic logic [7:0] mul13(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
	endfunction
	function automatic logic [7:0] mul14(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
	endfunction

	// Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, then InvMixColumns.
	function automatic logic [BLK_BITS-1:0] dec_round(input logic [BLK_BITS-1:0] s,
			input logic [BLK_BITS-1:0] k, input logic last_rnd);
		logic [7:0] b [16];
		logic [7:0] o [16];
		logic [7:0] a0, a1, a2, a3;
		logic [BLK_BITS-1:0] r;
		for (int i = 0; i < 16; i++) b[i] = byte_of(s, i);
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				o[rr + 4*((c + rr) & 3)] = inv_sbox(b[rr + 4*c]);
		for (int i = 0; i < 16; i++) o[i] = o[i] ^ byte_of(k, i);
		if (!last_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
				o[4*c]   = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
				o[4*c+1] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
				o[4*c+2] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
				o[4*c+3] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
			end
		end
		for (int i = 0; i < 16; i++) r[BLK_BITS-1-8*i -: 8] = o[i];
		return r;
	endfunction

	// One step of the key schedule: round key r from round key r-1.
	function automatic logic [BLK_BITS-1:0] next_key(input logic [BLK_BITS-1:0] k,
			input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

/* hdl/aes128_cbc_pkcs7_cipher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC cipher core with PKCS#7 padding
// Encrypts or decrypts one 16-byte block per transfer with CBC chaining.
// One block at a time: no new block is accepted until its result is emitted.
// Each block passes through the shared round unit (whitening step plus ten
// rounds) and the result stage.
// A full last encrypt block adds a padding block after it.
// Reset clears control; the key schedule then fills the round-key RAM, and
// again after each key write, while no block is accepted.
// ----------------------------------------------------------------------------
module aes128_cbc_pkcs7_cipher_core #(
	parameter int KEY_BITS = aes_cbc_pkg::KEY_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // data_hi[63:0], data_lo[127:64], byte_count[132:128]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // out_hi[63:0], out_lo[127:64], out_bytes[132:128]
	output logic         m_tlast,
	output logic         m_tuser    // status
);
	aes_cbc_pkg::dp_cmd_t cmd;
	aes_cbc_pkg::dp_sts_t sts;
	logic in_fire, ks_busy, mode, emit, emit_last, emit_dec, out_free, res_bad;
	logic [127:0] result;
	logic [4:0]   res_bytes;
	logic [4:0]   in_count;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign in_count = s_tdata[132:128];

	aes_cbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.in_full(in_count >= 5'd16), .decrypt(mode), .ks_busy(ks_busy),
		.out_free(out_free), .sts(sts), .ready(s_tready), .cmd(cmd),
		.emit(emit), .emit_last(emit_last), .emit_dec(emit_dec));

	aes_cbc_dp #(.KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_block({s_tdata[63:0], s_tdata[127:64]}),
		.in_count(in_count), .in_last(s_tlast), .cmd(cmd), .sts(sts),
		.ks_busy(ks_busy), .mode_q(mode), .result(result),
		.res_bytes(res_bytes), .res_bad(res_bad));

	// Output register: a result stays here until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {3'b000, (emit_dec && emit_last) ? res_bytes : 5'd16,
				result[63:0], result[127:64]};
			m_tlast <= emit_last;
			m_tuser <= emit_dec && emit_last && res_bad;
		end
	end
endmodule

/* hdl/aes_cbc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/aes_cbc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CBC controller
// Sequences the rounds of one block, the extra pad block and output handshake.
// ----------------------------------------------------------------------------
module aes_cbc_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic                     in_last,
	input  logic                     in_full,
	input  logic                     decrypt,
	input  logic                     ks_busy,
	input  logic                     out_free,
	input  aes_cbc_pkg::dp_sts_t     sts,
	output logic                     ready,
	output aes_cbc_pkg::dp_cmd_t     cmd,
	output logic                     emit,
	output logic                     emit_last,
	output logic                     emit_dec
);
	typedef enum logic [1:0] {IDLE, RUN, EMIT} state_t;

	state_t state_q;
	logic   last_q, pad_q, dec_q;

	assign ready = (state_q == IDLE) && !ks_busy;

	always_comb begin
		cmd          = '0;
		cmd.decrypt  = dec_q;
		cmd.load     = in_fire;
		emit         = 1'b0;
		emit_last    = last_q && !pad_q;
		emit_dec     = dec_q;
		if (in_fire) cmd.decrypt = decrypt;
		case (state_q)
			RUN: begin
				cmd.round = 1'b1;
			end
			EMIT: begin
				if (out_free) begin
					emit         = 1'b1;
					cmd.commit   = 1'b1;
					cmd.pad_load = pad_q;
					cmd.chain_iv = last_q && !pad_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			dec_q   <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_fire) begin
						state_q <= RUN;
						last_q  <= in_last;
						dec_q   <= decrypt;
						pad_q   <= in_last && in_full && !decrypt;
					end
				end
				RUN: begin
					if (sts.final_round) state_q <= EMIT;
				end
				EMIT: begin
					if (out_free) begin
						if (pad_q) begin
							pad_q   <= 1'b0;
							state_q <= RUN;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !ready) else $error("accept while busy");
	a_pad_enc: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> !dec_q) else $error("pad block in decrypt");
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q == EMIT)) else $error("emit outside EMIT");
endmodule

/* hdl/aes_cbc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CBC datapath
// Key schedule into RAM, one shared round unit, chain register, padding logic.
// ----------------------------------------------------------------------------
module aes_cbc_dp #(
	parameter int KEY_BITS = aes_cbc_pkg::KEY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [aes_cbc_pkg::IDX_W-1:0] cfg_idx,
	input  logic [63:0]              cfg_data,
	input  logic [127:0]             in_block,
	input  logic [4:0]               in_count,
	input  logic                     in_last,
	input  aes_cbc_pkg::dp_cmd_t     cmd,
	output aes_cbc_pkg::dp_sts_t     sts,
	output logic                     ks_busy,
	output logic                     mode_q,
	output logic [127:0]             result,
	output logic [4:0]               res_bytes,
	output logic                     res_bad
);
	localparam int NR  = KEY_BITS / 32 + 6;
	localparam int RKW = $clog2(NR + 1);

	logic [KEY_BITS-1:0] key_q;
	logic [127:0]        iv_q, chain_q, state_q, cin_q;
	logic [RKW-1:0]      rnd_q, ks_idx_q, raddr;
	logic [127:0]        ks_key_q, rk;
	logic                ks_run_q, ks_we, key_wr;
	logic [RKW-1:0]      ks_waddr;
	logic [127:0]        ks_wdata, nk, plain, rnd_out;
	logic                whiten_q;

	// Key schedule: one round key per cycle into the RAM after reset or a key write.
	assign nk       = aes_cbc_pkg::next_key(ks_key_q, aes_cbc_pkg::RCON[ks_idx_q - RKW'(1)]);
	assign ks_we    = ks_run_q;
	assign ks_waddr = ks_idx_q;
	assign ks_wdata = (ks_idx_q == '0) ? ks_key_q : nk;
	assign ks_busy  = ks_run_q;
	assign key_wr   = cfg_we && (cfg_idx inside {aes_cbc_pkg::REG_KEYHI, aes_cbc_pkg::REG_KEYLO});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			iv_q     <= '0;
			chain_q  <= '0;
			mode_q   <= 1'b0;
			ks_run_q <= 1'b1;
			ks_idx_q <= '0;
			ks_key_q <= '0;
		end else begin
			if (ks_run_q && !key_wr) begin
				ks_key_q <= ks_wdata;
				if (ks_idx_q == RKW'(NR)) ks_run_q <= 1'b0;
				else ks_idx_q <= ks_idx_q + RKW'(1);
			end
			if (cfg_we) begin
				case (cfg_idx)
					aes_cbc_pkg::REG_MODE:  mode_q <= cfg_data[0];
					aes_cbc_pkg::REG_KEYHI: begin
						key_q[127:64] <= cfg_data;
						ks_key_q      <= {cfg_data, key_q[63:0]};
						ks_idx_q      <= '0;
						ks_run_q      <= 1'b1;
					end
					aes_cbc_pkg::REG_KEYLO: begin
						key_q[63:0] <= cfg_data;
						ks_key_q    <= {key_q[127:64], cfg_data};
						ks_idx_q    <= '0;
						ks_run_q    <= 1'b1;
					end
					aes_cbc_pkg::REG_IVHI: begin
						iv_q[127:64]    <= cfg_data;
						chain_q[127:64] <= cfg_data;
					end
					aes_cbc_pkg::REG_IVLO: begin
						iv_q[63:0]    <= cfg_data;
						chain_q[63:0] <= cfg_data;
					end
					default: ;
				endcase
			end
			if (cmd.commit) begin
				if (cmd.chain_iv)     chain_q <= iv_q;
				else if (cmd.decrypt) chain_q <= cin_q;
				else                  chain_q <= state_q;
			end
		end
	end

	aes_cbc_ram #(.WIDTH(128), .DEPTH(NR + 1)) u_rk (
		.clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
		.raddr(raddr), .rdata(rk));

	// Padding of the last encrypt block; counts above 16 saturate.
	always_comb begin
		logic [4:0] cnt;
		cnt   = (in_count > 5'd16) ? 5'd16 : in_count;
		plain = in_block;
		if (in_last && !cmd.decrypt && cnt != 5'd16)
			for (int i = 0; i < 16; i++)
				if (5'(i) >= cnt) plain[127-8*i -: 8] = 8'(5'd16 - cnt);
	end

	// Round 0 of a block is the whitening add; its key is read at load and added in the first RUN step.
	// Address for the next cycle's round key: the whitening step fetches the
	// key of round 1, each round but the last fetches the key of the round after it.
	always_comb begin
		raddr = cmd.decrypt ? RKW'(NR) : '0;
		if (cmd.pad_load) begin
			raddr = '0;
		end else if (cmd.round && (whiten_q || rnd_q != RKW'(NR - 1))) begin
			if (cmd.decrypt) raddr = whiten_q ? RKW'(NR - 1) : RKW'(NR) - rnd_q - RKW'(2);
			else raddr = whiten_q ? RKW'(1) : rnd_q + RKW'(2);
		end
	end

	assign rnd_out = cmd.decrypt
		? aes_cbc_pkg::dec_round(state_q, rk, rnd_q == RKW'(NR - 1))
		: aes_cbc_pkg::enc_round(state_q, rk, rnd_q == RKW'(NR - 1));
	assign sts.final_round = cmd.round && (rnd_q == RKW'(NR - 1));

	// state_q holds the input until the first round key arrives: whitening is
	// folded into a setup step (marked by whiten_q, with rnd_q at zero).
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cin_q    <= in_block;
			state_q  <= cmd.decrypt ? in_block : (plain ^ chain_q);
			whiten_q <= 1'b1;
			rnd_q    <= '0;
		end else if (cmd.pad_load) begin
			state_q  <= {16{8'h10}} ^ state_q;
			whiten_q <= 1'b1;
			rnd_q    <= '0;
		end else if (cmd.round) begin
			if (whiten_q) begin
				state_q  <= state_q ^ rk;
				whiten_q <= 1'b0;
			end else begin
				state_q <= rnd_out;
				rnd_q   <= rnd_q + RKW'(1);
			end
		end
	end

	// Result and padding check.
	always_comb begin
		logic [7:0] pad;
		logic       bad;
		result = cmd.decrypt ? (state_q ^ chain_q) : state_q;
		pad    = result[7:0];
		bad    = (pad == 8'd0) || (pad > 8'd16);
		for (int i = 0; i < 16; i++)
			if (8'(i) >= 8'd16 - pad && result[127-8*i -: 8] != pad) bad = 1'b1;
		res_bad   = bad;
		res_bytes = bad ? 5'd16 : 5'(8'd16 - pad);
	end
endmodule
